>>> hdl/bnc_pkg.sv
// bnc_pkg: shared constants, item types and bracket decode for the bracket nesting checker
// no dependencies; imported by bnc_ram users, bnc_out_buf and bracket_nesting_checker
package bnc_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int KIND_W      = 2;
    localparam int DEPTH_W     = 8;

    localparam logic [DEPTH_W-1:0] DEPTH_SAT = 8'd255;

    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_ANGLE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } decode_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic               corrupted;
        logic [7:0]         offending_char;
        logic [DEPTH_W-1:0] open_depth;
        logic               overflow;
    } out_item_t;

    function automatic decode_t decode_open(logic [7:0] b);
        decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_PAREN;
        unique case (b)
            CH_OPEN_PAREN:  d.kind = KIND_PAREN;
            CH_OPEN_SQUARE: d.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  d.kind = KIND_CURLY;
            CH_OPEN_ANGLE:  d.kind = KIND_ANGLE;
            default:        d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic decode_t decode_close(logic [7:0] b);
        decode_t d;
        d.hit  = 1'b1;
        d.kind = KIND_PAREN;
        unique case (b)
            CH_CLOSE_PAREN:  d.kind = KIND_PAREN;
            CH_CLOSE_SQUARE: d.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  d.kind = KIND_CURLY;
            CH_CLOSE_ANGLE:  d.kind = KIND_ANGLE;
            default:         d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/bnc_ram.sv
// bnc_ram: generic single-clock ram, one write port, one read port, registered read data
// no dependencies
module bnc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bnc_out_buf.sv
// bnc_out_buf: two-entry output buffer (output register plus skid) for result items
// depends on bnc_pkg for the result item type
module bnc_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bnc_pkg::out_item_t  push_data,
    output logic                push_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output bnc_pkg::out_item_t  m_data
);
    import bnc_pkg::*;

    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg) begin
            // no push while skid holds an item
            if (m_ready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push && (!out_valid_reg || m_ready)) begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule

>>> hdl/bracket_nesting_checker.sv
// bracket_nesting_checker: one item per cycle while the output buffer has room; the result of a line
// is registered into the output register (or the skid register when the output stalls) as its line_end item is accepted
// rate is set by the top-of-stack register and the registered stack ram read with push forwarding
// reset clears the depth counter, the line latches and the forwarding flag only; stack contents are left as they are
// and need no clearing pass, so items are accepted from the first cycle after reset
// depends on bnc_pkg, bnc_ram and bnc_out_buf
module bracket_nesting_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bnc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bnc_pkg::out_item_t m_data
);
    import bnc_pkg::*;

    // stack layout: the top entry lives in top_reg, every entry below it in the ram
    // entry i of the stack (i < count-1) sits at ram address i

    logic [CNT_W-1:0] count_reg, count_next;
    logic             bad_reg, bad_next;
    logic [7:0]       bad_byte_reg, bad_byte_next;
    logic             ovf_reg, ovf_next;
    kind_t            top_reg, top_next;

    // forwarding for the entry just below the top when it was written by the last push
    logic             fwd_reg, fwd_next;
    kind_t            fwd_kind_reg, fwd_kind_next;

    logic              take;
    logic              buf_ready;
    logic              res_push;
    out_item_t         res_item;
    decode_t           dec_open;
    decode_t           dec_close;
    kind_t             second;
    logic [KIND_W-1:0] ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CNT_W-1:0]  below_idx;

    assign s_ready = buf_ready;
    assign take    = s_valid && s_ready;

    assign dec_open  = decode_open(s_data.symbol);
    assign dec_close = decode_close(s_data.symbol);

    // entry below the top: freshly pushed value, else the ram read of count-2
    assign second = fwd_reg ? fwd_kind_reg : kind_t'(ram_rdata);

    always_comb begin
        count_next    = count_reg;
        bad_next      = bad_reg;
        bad_byte_next = bad_byte_reg;
        ovf_next      = ovf_reg;
        top_next      = top_reg;
        fwd_next      = 1'b0;
        fwd_kind_next = top_reg;
        ram_we        = 1'b0;
        ram_waddr     = ADDR_W'(count_reg - CNT_W'(1));

        if (take && !bad_reg) begin
            priority if (dec_open.hit) begin
                if (count_reg < CNT_W'(STACK_DEPTH)) begin
                    // old top sinks into the ram, new kind becomes the top
                    if (count_reg != '0) begin
                        ram_we        = 1'b1;
                        fwd_next      = 1'b1;
                        fwd_kind_next = top_reg;
                    end
                    top_next   = dec_open.kind;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    // full stack: push dropped
                    ovf_next = 1'b1;
                end
            end else if (dec_close.hit) begin
                if (count_reg != '0 && top_reg == dec_close.kind) begin
                    top_next   = second;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    bad_next      = 1'b1;
                    bad_byte_next = s_data.symbol;
                end
            end else begin
                // other bytes leave the stack alone
                count_next = count_reg;
            end
        end

        // report uses the state after the last byte of the line
        res_push                = take && s_data.line_end;
        res_item.corrupted      = bad_next;
        res_item.offending_char = bad_next ? bad_byte_next : 8'd0;
        res_item.overflow       = ovf_next;
        res_item.open_depth     = (count_next > CNT_W'(DEPTH_SAT)) ?
                                  DEPTH_SAT : DEPTH_W'(count_next);

        if (res_push) begin
            count_next    = '0;
            bad_next      = 1'b0;
            bad_byte_next = 8'd0;
            ovf_next      = 1'b0;
            fwd_next      = 1'b0;
        end
    end

    // read the entry that will sit below the top next cycle
    assign below_idx = count_next - CNT_W'(2);
    assign ram_raddr = below_idx[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            bad_reg      <= 1'b0;
            bad_byte_reg <= 8'd0;
            ovf_reg      <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            count_reg    <= count_next;
            bad_reg      <= bad_next;
            bad_byte_reg <= bad_byte_next;
            ovf_reg      <= ovf_next;
            fwd_reg      <= fwd_next;
        end
        top_reg      <= top_next;
        fwd_kind_reg <= fwd_kind_next;
    end

    // stack storage below the top entry
    bnc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register and skid stage
    bnc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_push),
        .push_data  (res_item),
        .push_ready (buf_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");
    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_data.line_end) |=> (count_reg == '0 && !bad_reg && !ovf_reg))
        else $error("line state not cleared after line end");
    a_bad_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (bad_reg && !(take && s_data.line_end)) |=>
        (bad_reg && $stable(bad_byte_reg) && $stable(count_reg)))
        else $error("corruption latch or stack moved after corruption");
    a_fwd_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> count_reg >= CNT_W'(2))
        else $error("forwarded entry with fewer than two entries on stack");
`endif

endmodule
